// File: hw/rtl/tcce_pkg.sv
package tcce_pkg;

  // Fixed field widths
  localparam int COLUMN_W = 7;
  localparam int ROW_W    = 5;
  localparam int GLYPH_W  = 8;
  localparam int RGB_W    = 24;
  localparam int MODE_W   = 2;

  // Parameter defaults
  localparam int COLUMNS_DEF     = 80;
  localparam int ROWS_DEF        = 24;
  localparam int NUMBER_BITS_DEF = 32;

  // Results per input word beyond this are dropped
  localparam int MAX_RESULTS = 20;
  localparam int RCOUNT_W    = $clog2(MAX_RESULTS + 1);

  // Output word: column, row, glyph, fore, back, padded to bytes
  localparam int M_FIELDS_W = COLUMN_W + ROW_W + GLYPH_W + 2 * RGB_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_CHAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX  = 2'd2;

  // Output commands
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_SCROLL = 1'b1;

  localparam logic [GLYPH_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [GLYPH_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [GLYPH_W-1:0] ZERO_CHAR    = 8'h30;
  localparam logic [GLYPH_W-1:0] LOWER_A_CHAR = 8'h61;
  localparam logic [3:0]         DIGIT_TEN    = 4'd10;

  // Byte stream from the digit unit to the cursor unit
  typedef struct packed {
    logic               valid;
    logic [GLYPH_W-1:0] code;
    logic               last;
  } byte_word_t;

  // Registered result word, colors are added at the top level
  typedef struct packed {
    logic                valid;
    logic                command;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic [GLYPH_W-1:0]  glyph;
    logic                last;
  } result_t;

  function automatic logic [GLYPH_W-1:0] digit_ascii(input logic [3:0] d);
    logic [GLYPH_W-1:0] code;
    if (d < DIGIT_TEN) begin
      code = ZERO_CHAR + {4'b0000, d};
    end else begin
      code = LOWER_A_CHAR + {4'b0000, d - DIGIT_TEN};
    end
    return code;
  endfunction

endpackage

// File: hw/rtl/text_console_cursor_engine_unit.sv
// Text console cursor engine.
// Input stream (s_*): one word is a character (mode 0), a number printed in
// decimal (mode 1) or in lowercase hex (mode 2); mode 3 words are taken and
// dropped. Output stream (m_*): draw commands (glyph at column/row) and
// scroll-up-and-clear-bottom commands, both carrying the configured colors;
// m_tlast marks the final command caused by one input word.
// APB port: register 0 at address 0 is the foreground color, register 1 at
// address 4 the background color; pready is tied high.
// Flow: one input word is worked on at a time. A decimal number goes through
// serial double dabble, then leading-zero stripping, then each digit is sent,
// with an extra scroll step when a scroll follows. Hex skips the double
// dabble. The cursor unit takes a byte in C_TAKE and draws it in C_DRAW,
// so its take/draw loop sets the per-digit cost.
// Reset: cursor to column 0, row 0, foreground white, background black.
// When m_tready is low the output register holds its word and the cursor
// and digit units stall; no command is lost.
module text_console_cursor_engine_unit #(
  parameter int COLUMNS     = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS        = tcce_pkg::ROWS_DEF,
  parameter int NUMBER_BITS = tcce_pkg::NUMBER_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // input word
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // tdata: char_code[7:0], number[NUMBER_BITS+7:8], zero padding
  input  logic [((NUMBER_BITS + 15) / 8) * 8-1:0] s_tdata,
  // tuser: mode[1:0]
  input  logic [tcce_pkg::MODE_W-1:0]           s_tuser,
  // output word
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // tdata: column[6:0], row[11:7], glyph[19:12], fore_rgb[43:20],
  //        back_rgb[67:44], zero padding
  output logic [tcce_pkg::M_TDATA_W-1:0]        m_tdata,
  // tuser: command[0]
  output logic                                  m_tuser,
  output logic                                  m_tlast,
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [2:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int RGB_W = tcce_pkg::RGB_W;

  logic [RGB_W-1:0]     fore_color;
  logic [RGB_W-1:0]     back_color;
  logic                 cfg_write;
  tcce_pkg::byte_word_t byte_word;
  logic                 byte_ready;
  tcce_pkg::result_t    result;

  // register index is paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = paddr[2] ? {8'h00, back_color} : {8'h00, fore_color};

  always_ff @(posedge clk) begin
    if (rst) begin
      fore_color <= 24'hffffff;
      back_color <= 24'h000000;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        back_color <= pwdata[RGB_W-1:0];
      end else begin
        fore_color <= pwdata[RGB_W-1:0];
      end
    end
  end

  tcce_digit_unit #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_digit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tuser),
    .char_code  (s_tdata[7:0]),
    .number     (s_tdata[NUMBER_BITS+7:8]),
    .byte_out   (byte_word),
    .byte_ready (byte_ready)
  );

  tcce_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_word),
    .byte_ready   (byte_ready),
    .result       (result),
    .result_ready (m_tready)
  );

  // colors are to be changed only while idle (the block does not enforce it), so they are added at the port
  assign m_tvalid = result.valid;
  assign m_tuser  = result.command;
  assign m_tlast  = result.last;
  assign m_tdata  = {{(tcce_pkg::M_TDATA_W - tcce_pkg::M_FIELDS_W){1'b0}},
                     back_color, fore_color, result.glyph, result.row, result.column};

endmodule

// File: hw/rtl/tcce_digit_unit.sv
// Front end: turns one input word into a stream of bytes.
// Decimal goes through a bit-serial double dabble, hex loads nibbles directly.
module tcce_digit_unit #(
  parameter int NUMBER_BITS = tcce_pkg::NUMBER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcce_pkg::MODE_W-1:0]  mode,
  input  logic [tcce_pkg::GLYPH_W-1:0] char_code,
  input  logic [NUMBER_BITS-1:0]       number,
  output tcce_pkg::byte_word_t         byte_out,
  input  logic                         byte_ready
);

  localparam int DIGITS = (NUMBER_BITS * 30103) / 100000 + 1;
  localparam int BUF_W  = DIGITS * 4;
  localparam int REM_W  = $clog2(DIGITS + 1);
  localparam int CNT_W  = $clog2(NUMBER_BITS + 1);

  typedef enum logic [1:0] {F_IDLE, F_DABBLE, F_STRIP, F_SEND} fstate_t;

  fstate_t                      state;
  logic                         is_char;
  logic [tcce_pkg::GLYPH_W-1:0] char_reg;
  logic [BUF_W-1:0]             digits;
  logic [BUF_W-1:0]             adjusted;
  logic [NUMBER_BITS-1:0]       bits;
  logic [CNT_W-1:0]             cnt;
  logic [REM_W-1:0]             rem;
  logic [3:0]                   top_digit;
  logic                         send_last;

  assign top_digit = digits[BUF_W-1 -: 4];
  assign send_last = is_char || (rem == REM_W'(1));
  assign in_ready  = (state == F_IDLE);

  assign byte_out.valid = (state == F_SEND);
  assign byte_out.code  = is_char ? char_reg : tcce_pkg::digit_ascii(top_digit);
  assign byte_out.last  = send_last;

  // add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (digits[i*4 +: 4] >= 4'd5) begin
        adjusted[i*4 +: 4] = digits[i*4 +: 4] + 4'd3;
      end else begin
        adjusted[i*4 +: 4] = digits[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            char_reg <= char_code;
            bits     <= number;
            rem      <= REM_W'(DIGITS);
            if (mode == tcce_pkg::MODE_CHAR) begin
              is_char <= 1'b1;
              state   <= F_SEND;
            end else if (mode == tcce_pkg::MODE_DEC) begin
              is_char <= 1'b0;
              digits  <= '0;
              cnt     <= CNT_W'(NUMBER_BITS);
              state   <= F_DABBLE;
            end else if (mode == tcce_pkg::MODE_HEX) begin
              is_char <= 1'b0;
              digits  <= {{(BUF_W - NUMBER_BITS){1'b0}}, number};
              state   <= F_STRIP;
            end
          end
        end
        F_DABBLE: begin
          digits <= {adjusted[BUF_W-2:0], bits[NUMBER_BITS-1]};
          bits   <= {bits[NUMBER_BITS-2:0], 1'b0};
          cnt    <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= F_STRIP;
          end
        end
        F_STRIP: begin
          // drop leading zeros, keep at least one digit
          if (rem != REM_W'(1) && top_digit == 4'd0) begin
            digits <= {digits[BUF_W-5:0], 4'd0};
            rem    <= rem - REM_W'(1);
          end else begin
            state <= F_SEND;
          end
        end
        F_SEND: begin
          if (byte_ready) begin
            if (send_last) begin
              state <= F_IDLE;
            end else begin
              digits <= {digits[BUF_W-5:0], 4'd0};
              rem    <= rem - REM_W'(1);
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/tcce_cursor.sv
// Cursor tracking and command generation with a registered output word.
module tcce_cursor #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcce_pkg::byte_word_t byte_in,
  output logic                 byte_ready,
  output tcce_pkg::result_t    result,
  input  logic                 result_ready
);

  localparam int CW = tcce_pkg::COLUMN_W;
  localparam int RW = tcce_pkg::ROW_W;
  localparam int NW = tcce_pkg::RCOUNT_W;

  typedef enum logic [1:0] {C_TAKE, C_DRAW, C_SCROLL} cstate_t;

  cstate_t                      state;
  logic [CW-1:0]                col;
  logic [RW-1:0]                row;
  logic [tcce_pkg::GLYPH_W-1:0] code;
  logic                         byte_last;
  logic [NW-1:0]                rcount;
  logic [NW-1:0]                rcount_inc;
  logic                         out_free;
  logic                         room;
  logic                         at_cap;
  logic                         wrap;
  logic                         bottom;
  logic                         emit;

  assign byte_ready = (state == C_TAKE);
  assign out_free   = !result.valid || result_ready;
  assign room       = (rcount < NW'(tcce_pkg::MAX_RESULTS));
  assign at_cap     = (rcount == NW'(tcce_pkg::MAX_RESULTS - 1));
  assign rcount_inc = room ? rcount + NW'(1) : rcount;
  assign wrap       = (col == CW'(COLUMNS - 1));
  assign bottom     = (row == RW'(ROWS - 1));
  // a new word goes into the output register this cycle
  assign emit       = out_free && room && (state == C_DRAW || state == C_SCROLL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= C_TAKE;
      col          <= '0;
      row          <= '0;
      rcount       <= '0;
      result.valid <= 1'b0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result_ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        C_TAKE: begin
          if (byte_in.valid) begin
            code      <= byte_in.code;
            byte_last <= byte_in.last;
            if (byte_in.code == tcce_pkg::NEWLINE_CODE) begin
              col <= '0;
              if (bottom) begin
                state <= C_SCROLL;
              end else begin
                row <= row + RW'(1);
                if (byte_in.last) begin
                  rcount <= '0;
                end
              end
            end else begin
              state <= C_DRAW;
            end
          end
        end
        C_DRAW: begin
          if (out_free) begin
            if (room) begin
              result.command <= tcce_pkg::CMD_DRAW;
              result.column  <= col;
              result.row     <= row;
              result.glyph   <= code;
              result.last    <= (byte_last && !(wrap && bottom)) || at_cap;
            end
            // count restarts once the word's final command is out
            rcount <= (byte_last && !(wrap && bottom)) ? '0 : rcount_inc;
            if (wrap) begin
              col <= '0;
              if (bottom) begin
                state <= C_SCROLL;
              end else begin
                row   <= row + RW'(1);
                state <= C_TAKE;
              end
            end else begin
              col   <= col + CW'(1);
              state <= C_TAKE;
            end
          end
        end
        C_SCROLL: begin
          if (out_free) begin
            if (room) begin
              result.command <= tcce_pkg::CMD_SCROLL;
              result.column  <= '0;
              result.row     <= RW'(ROWS - 1);
              result.glyph   <= tcce_pkg::SPACE_CODE;
              result.last    <= byte_last || at_cap;
            end
            rcount <= byte_last ? '0 : rcount_inc;
            state  <= C_TAKE;
          end
        end
        default: state <= C_TAKE;
      endcase
    end
  end

endmodule
